// ----- src/ptb_pkg.sv -----
// Shared constants and types for the periodic timer bank.
`default_nettype none
package ptb_pkg;

    localparam int TIMER_SLOTS = 8;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_BITS    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int USED_BITS   = $clog2(TIMER_SLOTS + 1);

    // Field widths fixed by the stream format.
    localparam int CMD_BITS      = 2;
    localparam int SLOT_BITS     = 3;
    localparam int INTERVAL_BITS = 16;
    localparam int KIND_BITS     = 2;

    localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ALLOC  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CHANGE = 2'd2;

    localparam logic [KIND_BITS-1:0] KIND_EXPIRED = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_GRANTED = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_REFUSED = 2'd2;

    typedef struct packed {
        logic                  load;
        logic                  step;
        logic [IDX_BITS-1:0]   idx;
        logic [COUNT_BITS-1:0] interval;
    } t_store_ctl;

endpackage
`default_nettype wire

// ----- src/ptb_slot_store.sv -----
// Slot interval and count registers with the shared increment and compare unit.
`default_nettype none
module ptb_slot_store (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ptb_pkg::t_store_ctl   i_ctl,
    output logic                       o_fire
);

    logic [ptb_pkg::COUNT_BITS-1:0] r_interval [ptb_pkg::TIMER_SLOTS];
    logic [ptb_pkg::COUNT_BITS-1:0] r_count    [ptb_pkg::TIMER_SLOTS];
    logic [ptb_pkg::COUNT_BITS-1:0] count_inc;

    // The one incrementer and comparator, applied to the addressed slot.
    assign count_inc = r_count[i_ctl.idx] + ptb_pkg::COUNT_BITS'(1);
    assign o_fire    = (count_inc == r_interval[i_ctl.idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ptb_pkg::TIMER_SLOTS; i++) begin
                r_interval[i] <= '0;
                r_count[i]    <= '0;
            end
        end else if (i_ctl.load) begin
            r_interval[i_ctl.idx] <= i_ctl.interval;
            r_count[i_ctl.idx]    <= '0;
        end else if (i_ctl.step) begin
            r_count[i_ctl.idx] <= o_fire ? '0 : count_inc;
        end
    end

endmodule
`default_nettype wire

// ----- src/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: command sequencer and result register.
// Usage: commands enter on the slave stream; i_s_tuser carries the command
// (0 tick, 1 allocate, 2 change), i_s_tdata the slot and the interval.
// Results leave on the master stream: o_m_tuser is the result kind, o_m_tdata
// the slot number, and o_m_tlast marks the final result of one command.
// An allocate gives one result (granted or refused) in the cycle after it is
// taken. A change gives no result.
// A tick walks the allocated slots one per cycle through a single incrementer
// and comparator (up to 8 slots), then sends the expiries, highest slot first.
// No new command is taken while a tick is being walked or its expiries sent.
// A single output register separates the two sides; a command is taken while
// a result still waits only if that result is being taken in the same cycle.
// When the receiver stalls, the sequencer holds and loses nothing.
// Reset (synchronous, active low) frees every slot and clears all intervals
// and counts; no result is pending after reset.
`default_nettype none
module periodic_timer_bank (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // slot [2:0], interval [18:3], zero [23:19]
    input  wire logic [1:0]  i_s_tuser,  // cmd [1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // timer_slot [2:0], zero [7:3]
    output logic [1:0]       o_m_tuser,  // result_kind [1:0]
    output logic             o_m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                       r_state, n_state;
    logic [ptb_pkg::IDX_BITS-1:0]     r_idx, n_idx;
    logic [ptb_pkg::USED_BITS-1:0]    r_used, n_used;
    logic [ptb_pkg::TIMER_SLOTS-1:0]  r_fired, n_fired;
    logic                             r_out_valid, n_out_valid;
    logic [ptb_pkg::KIND_BITS-1:0]    r_out_kind, n_out_kind;
    logic [ptb_pkg::SLOT_BITS-1:0]    r_out_slot, n_out_slot;
    logic                             r_out_last, n_out_last;

    logic [ptb_pkg::CMD_BITS-1:0]      in_cmd;
    logic [ptb_pkg::SLOT_BITS-1:0]     in_slot;
    logic [ptb_pkg::INTERVAL_BITS-1:0] in_interval;
    logic                              out_free;
    logic                              in_take;
    logic                              fire;
    logic [ptb_pkg::IDX_BITS-1:0]      top_idx;
    logic [ptb_pkg::TIMER_SLOTS-1:0]   top_bit;
    ptb_pkg::t_store_ctl               store_ctl;

    assign in_cmd      = i_s_tuser;
    assign in_slot     = i_s_tdata[2:0];
    assign in_interval = i_s_tdata[18:3];

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign in_take    = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_slot};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    ptb_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (store_ctl),
        .o_fire  (fire)
    );

    // Highest expired slot still to be sent.
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < ptb_pkg::TIMER_SLOTS; i++) begin
            if (r_fired[i]) begin
                top_idx = ptb_pkg::IDX_BITS'(i);
            end
        end
        top_bit = '0;
        top_bit[top_idx] = 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_fired     = r_fired;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;

        store_ctl.load     = 1'b0;
        store_ctl.step     = 1'b0;
        store_ctl.idx      = r_idx;
        store_ctl.interval = ptb_pkg::COUNT_BITS'(in_interval);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    unique case (in_cmd)
                        ptb_pkg::CMD_ALLOC: begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            if (r_used < ptb_pkg::USED_BITS'(ptb_pkg::TIMER_SLOTS)) begin
                                store_ctl.load = 1'b1;
                                store_ctl.idx  = ptb_pkg::IDX_BITS'(r_used);
                                n_used         = r_used + ptb_pkg::USED_BITS'(1);
                                n_out_kind     = ptb_pkg::KIND_GRANTED;
                                n_out_slot     = ptb_pkg::SLOT_BITS'(r_used);
                            end else begin
                                n_out_kind = ptb_pkg::KIND_REFUSED;
                                n_out_slot = '0;
                            end
                        end
                        ptb_pkg::CMD_CHANGE: begin
                            if ({1'b0, in_slot} < 4'(ptb_pkg::TIMER_SLOTS)) begin
                                store_ctl.load = 1'b1;
                                store_ctl.idx  = ptb_pkg::IDX_BITS'(in_slot);
                            end
                        end
                        ptb_pkg::CMD_TICK: begin
                            if (r_used != '0) begin
                                n_state = ST_WALK;
                                n_idx   = '0;
                                n_fired = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                store_ctl.step = 1'b1;
                n_fired[r_idx] = fire;
                if (ptb_pkg::USED_BITS'(r_idx) + ptb_pkg::USED_BITS'(1) == r_used) begin
                    n_state = ((n_fired != '0)) ? ST_EMIT : ST_IDLE;
                end else begin
                    n_idx = r_idx + ptb_pkg::IDX_BITS'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ptb_pkg::KIND_EXPIRED;
                    n_out_slot  = ptb_pkg::SLOT_BITS'(top_idx);
                    n_out_last  = ((r_fired & ~top_bit) == '0);
                    n_fired     = r_fired & ~top_bit;
                    if ((r_fired & ~top_bit) == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_fired     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_used      <= n_used;
            r_fired     <= n_fired;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
        r_out_last <= n_out_last;
    end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the periodic timer bank: directed table and random streams.
`default_nettype none
module tb_top;

    localparam logic [ptb_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    localparam int     RESET_CYCLES    = 8;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     PHASE_ITEMS     = 20;
    localparam int     PRESSURE_ITEMS  = 20;
    localparam int     MAX_REPORTED    = 10;
    localparam longint CYCLE_LIMIT     = 3_000_000;

    typedef struct packed {
        logic [ptb_pkg::KIND_BITS-1:0] kind;
        logic [ptb_pkg::SLOT_BITS-1:0] tslot;
        logic                          last;
    } t_timer_result;

    typedef struct packed {
        logic [ptb_pkg::CMD_BITS-1:0]      cmd;
        logic [ptb_pkg::SLOT_BITS-1:0]     slot;
        logic [ptb_pkg::INTERVAL_BITS-1:0] interval;
        int unsigned                       reps;
        logic                              typed;
        logic [ptb_pkg::KIND_BITS-1:0]     kind;
        logic [ptb_pkg::SLOT_BITS-1:0]     tslot;
    } t_stim_row;

    // Rows marked typed carry their single result; all others go through the predictor.
    localparam int N_ROWS = 23;
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        '{ptb_pkg::CMD_TICK,   3'd0, 16'h0000, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{CMD_UNUSED,          3'd7, 16'hFFFF, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        // Slot not yet allocated.
        '{ptb_pkg::CMD_CHANGE, 3'd7, 16'h0002, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_ALLOC,  3'd0, 16'h0000, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd0},
        '{ptb_pkg::CMD_ALLOC,  3'd7, 16'hFFFF, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd1},
        '{ptb_pkg::CMD_ALLOC,  3'd0, 16'h0001, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd2},
        '{ptb_pkg::CMD_ALLOC,  3'd0, 16'h0002, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd3},
        '{ptb_pkg::CMD_ALLOC,  3'd0, 16'h0003, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd4},
        '{ptb_pkg::CMD_ALLOC,  3'd5, 16'h5555, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd5},
        '{ptb_pkg::CMD_TICK,   3'd7, 16'hFFFF, 3, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_CHANGE, 3'd4, 16'h0001, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_TICK,   3'd0, 16'h0000, 2, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_ALLOC,  3'd2, 16'hAAAA, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd6},
        // Slot 7 was changed while idle; allocation overwrites that interval.
        '{ptb_pkg::CMD_ALLOC,  3'd0, 16'h0004, 1, 1'b1, ptb_pkg::KIND_GRANTED, 3'd7},
        '{ptb_pkg::CMD_ALLOC,  3'd0, 16'h0009, 1, 1'b1, ptb_pkg::KIND_REFUSED, 3'd0},
        '{ptb_pkg::CMD_ALLOC,  3'd7, 16'hFFFF, 1, 1'b1, ptb_pkg::KIND_REFUSED, 3'd0},
        '{ptb_pkg::CMD_CHANGE, 3'd0, 16'h0001, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_CHANGE, 3'd1, 16'h0001, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_CHANGE, 3'd3, 16'h0001, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_CHANGE, 3'd5, 16'h0001, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_CHANGE, 3'd6, 16'h0001, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        '{ptb_pkg::CMD_TICK,   3'd0, 16'h0000, 3, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0},
        // On this tick slot 7 lines up with the rest, so all eight expire at once.
        '{ptb_pkg::CMD_TICK,   3'd0, 16'h0000, 1, 1'b0, ptb_pkg::KIND_EXPIRED, 3'd0}
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data  = '0;  // slot [2:0], interval [18:3], zero [23:19]
    logic [1:0]  s_user  = '0;  // cmd [1:0]
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;     // timer_slot [2:0], zero [7:3]
    logic [1:0]  o_m_tuser;     // result_kind [1:0]
    logic        o_m_tlast;

    // Predicted state of the bank.
    logic [ptb_pkg::COUNT_BITS-1:0] bank_interval [ptb_pkg::TIMER_SLOTS];
    logic [ptb_pkg::COUNT_BITS-1:0] bank_count    [ptb_pkg::TIMER_SLOTS];
    int                             slots_taken = 0;

    t_timer_result pending_results [$];

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_requests  = 0;
    int     hold_served    = 0;
    int     hold_left      = 0;
    int     failures       = 0;
    int     ticks_sent     = 0;
    int     allocs_sent    = 0;
    int     changes_sent   = 0;
    int     expiries_due   = 0;
    int     busiest_tick   = 0;
    longint cycles         = 0;

    periodic_timer_bank DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited.",
                     cycles, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic log_failure(input string why, input t_timer_result want,
                               input t_timer_result got);
        if (failures < MAX_REPORTED)
            $display("%0d: %s: expected kind %0d slot %0d last %0b, %s %0d slot %0d last %0b",
                     cycles, why, want.kind, want.tslot, want.last, "got kind",
                     got.kind, got.tslot, got.last);
        failures++;
    endtask

    // Applies one accepted item to the predicted bank and queues the results it causes.
    task automatic advance_bank(input logic [ptb_pkg::CMD_BITS-1:0] cmd,
                                input logic [ptb_pkg::SLOT_BITS-1:0] slot,
                                input logic [ptb_pkg::INTERVAL_BITS-1:0] interval,
                                input logic typed, input t_timer_result typed_result);
        t_timer_result                   fresh [$];
        logic [ptb_pkg::TIMER_SLOTS-1:0] expired;
        int                              n_expired;
        int                              seen;
        expired   = '0;
        n_expired = 0;
        seen      = 0;
        case (cmd)
            ptb_pkg::CMD_ALLOC: begin
                allocs_sent++;
                if (slots_taken < ptb_pkg::TIMER_SLOTS) begin
                    bank_interval[slots_taken] = interval;
                    bank_count[slots_taken]    = '0;
                    fresh.push_back('{ptb_pkg::KIND_GRANTED,
                                      ptb_pkg::SLOT_BITS'(slots_taken), 1'b1});
                    slots_taken++;
                end else begin
                    fresh.push_back('{ptb_pkg::KIND_REFUSED, '0, 1'b1});
                end
            end
            ptb_pkg::CMD_CHANGE: begin
                changes_sent++;
                if (int'(slot) < ptb_pkg::TIMER_SLOTS) begin
                    bank_interval[slot] = interval;
                    bank_count[slot]    = '0;
                end
            end
            ptb_pkg::CMD_TICK: begin
                ticks_sent++;
                for (int i = 0; i < slots_taken; i++) begin
                    bank_count[i] = bank_count[i] + 1'b1;
                    if (bank_count[i] == bank_interval[i]) begin
                        bank_count[i] = '0;
                        expired[i]    = 1'b1;
                        n_expired++;
                    end
                end
                for (int i = ptb_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
                    if (expired[i]) begin
                        seen++;
                        fresh.push_back('{ptb_pkg::KIND_EXPIRED, ptb_pkg::SLOT_BITS'(i),
                                          seen == n_expired});
                    end
                end
                expiries_due += n_expired;
                if (n_expired > busiest_tick)
                    busiest_tick = n_expired;
            end
            default: ;
        endcase
        if (typed)
            pending_results.push_back(typed_result);
        else
            foreach (fresh[i])
                pending_results.push_back(fresh[i]);
    endtask

    // Valid is only lowered when a gap is chosen, so back-to-back items keep it high.
    task automatic send_item(input logic [ptb_pkg::CMD_BITS-1:0] cmd,
                             input logic [ptb_pkg::SLOT_BITS-1:0] slot,
                             input logic [ptb_pkg::INTERVAL_BITS-1:0] interval,
                             input logic typed, input t_timer_result typed_result);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {5'b0, interval, slot};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        advance_bank(cmd, slot, interval, typed, typed_result);
    endtask

    // Mostly ticks with short intervals so that expiries are frequent.
    task automatic send_random_item(output logic counted);
        logic [ptb_pkg::CMD_BITS-1:0]      cmd;
        logic [ptb_pkg::INTERVAL_BITS-1:0] interval;
        int                                pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            cmd = CMD_UNUSED;
        else if (pick < 12)
            cmd = ptb_pkg::CMD_ALLOC;
        else if (pick < 40)
            cmd = ptb_pkg::CMD_CHANGE;
        else
            cmd = ptb_pkg::CMD_TICK;
        if ($urandom_range(0, 3) == 0)
            interval = ptb_pkg::INTERVAL_BITS'($urandom());
        else
            interval = ptb_pkg::INTERVAL_BITS'($urandom_range(1, 6));
        send_item(cmd, ptb_pkg::SLOT_BITS'($urandom_range(0, 7)), interval, 1'b0, '0);
        counted = (cmd != CMD_UNUSED);
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                got = '{o_m_tuser, o_m_tdata[ptb_pkg::SLOT_BITS-1:0], o_m_tlast};
                if (pending_results.size() == 0) begin
                    log_failure("unexpected item", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.tslot !== want.tslot
                            || got.last !== want.last)
                        log_failure("mismatch", want, got);
                end
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        t_timer_result typed_result;
        logic          counted;
        int            done;
        for (int i = 0; i < ptb_pkg::TIMER_SLOTS; i++) begin
            bank_interval[i] = '0;
            bank_count[i]    = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            typed_result = '{DIRECTED[r].kind, DIRECTED[r].tslot, 1'b1};
            for (int unsigned k = 0; k < DIRECTED[r].reps; k++)
                send_item(DIRECTED[r].cmd, DIRECTED[r].slot, DIRECTED[r].interval,
                          DIRECTED[r].typed, typed_result);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            done = 0;
            while (done < PHASE_ITEMS) begin
                send_random_item(counted);
                if (counted)
                    done++;
            end
        end

        // Long receiver hold-off while ticks keep coming, so the block backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (PRESSURE_ITEMS)
            send_item(ptb_pkg::CMD_TICK, ptb_pkg::SLOT_BITS'($urandom()),
                      ptb_pkg::INTERVAL_BITS'($urandom()), 1'b0, '0);

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d ticks with %0d expiries (at most %0d on one tick), %0d %s",
                 ticks_sent, expiries_due, busiest_tick, allocs_sent, "allocations");
        $display("and %0d interval changes, including refused allocations and a held output.",
                 changes_sent);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
